// ----- src/osc_pkg.sv -----
// Shared constants for the OSC message parser: characters, result kinds, defaults.
`default_nettype none

package osc_pkg;

    localparam int MAX_TAGS_DEFAULT = 16;

    localparam logic [7:0] CHAR_SLASH = 8'h2f;
    localparam logic [7:0] CHAR_COMMA = 8'h2c;
    localparam logic [7:0] CHAR_INT   = 8'h69;
    localparam logic [7:0] CHAR_FLOAT = 8'h66;
    localparam logic [7:0] CHAR_STR   = 8'h73;
    localparam logic [7:0] CHAR_BLOB  = 8'h62;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    typedef enum logic [3:0] {
        KIND_STATUS    = 4'd0,
        KIND_ADDR_BYTE = 4'd1,
        KIND_ADDR_END  = 4'd2,
        KIND_INT       = 4'd3,
        KIND_FLOAT     = 4'd4,
        KIND_STR_BYTE  = 4'd5,
        KIND_STR_END   = 4'd6,
        KIND_BLOB_LEN  = 4'd7,
        KIND_BLOB_BYTE = 4'd8
    } kind_t;

endpackage

`default_nettype wire

// ----- src/osc_message_parser.sv -----
// OSC 1.0 message parser: one packet byte per transfer in, at most one result per byte out.
//
// Takes one byte per clock and gives each result in the cycle after its byte is
// accepted; a new byte is accepted in every cycle in which the output register
// is empty or being taken, so throughput is one byte per cycle. The whole
// per-byte decode (phase update, word assembly, tag lookup) sits between the
// state registers and the output register. Type tags are held in a small shift
// queue of MAX_TAGS + 1 entries whose head is the tag of the current argument.
// Every byte with last_byte set gives one result with done_res set; error on
// that result flags a malformed packet, and after an error the rest of the
// packet gives no results but that one. All per-packet state clears after the last byte.
`default_nettype none

module osc_message_parser
    import osc_pkg::*;
#(
    parameter int MAX_TAGS = MAX_TAGS_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       kind,
    output logic [31:0]      value,
    output logic [3:0]       arg_index,
    output logic             done_res,
    output logic             error
);

    localparam int CNT_W  = $clog2(MAX_TAGS + 1);
    localparam int FIFO_D = MAX_TAGS + 1;

    typedef enum logic [3:0] {
        PH_ADDR_FIRST = 4'd0,
        PH_ADDR       = 4'd1,
        PH_ADDR_PAD   = 4'd2,
        PH_TAG_FIRST  = 4'd3,
        PH_TAG        = 4'd4,
        PH_TAG_PAD    = 4'd5,
        PH_WORD       = 4'd6,
        PH_STR        = 4'd7,
        PH_STR_PAD    = 4'd8,
        PH_BLOB       = 4'd9,
        PH_BLOB_PAD   = 4'd10,
        PH_TRAILER    = 4'd11
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [1:0]         pad_reg, pad_next;
    logic [CNT_W-1:0]   tag_count_reg, tag_count_next;
    logic [CNT_W-1:0]   arg_reg, arg_next;
    logic [31:0]        acc_reg, acc_next;
    logic [1:0]         wcnt_reg, wcnt_next;
    logic [30:0]        blob_reg, blob_next;
    logic               absorb_reg, absorb_next;
    logic [7:0]         tag_fifo_reg [FIFO_D];

    logic               out_valid_reg;
    kind_t              kind_reg, kind_next;
    logic [31:0]        value_reg, value_next;
    logic [3:0]         arg_out_reg, arg_out_next;
    logic               done_reg, done_next;
    logic               error_reg, error_next;

    logic               accept;
    logic               emit;
    logic               tag_write;
    logic               sel_req;
    logic               sel_first;
    logic               tag_shift;
    logic [1:0]         npos;
    logic               aligned;
    logic [CNT_W-1:0]   sel_idx;
    logic [7:0]         sel_tag;
    logic [30:0]        blob_dec;
    logic               absorb_final;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        phase_next     = phase_reg;
        pad_next       = pad_reg;
        tag_count_next = tag_count_reg;
        arg_next       = arg_reg;
        acc_next       = acc_reg;
        wcnt_next      = wcnt_reg;
        blob_next      = blob_reg;
        absorb_next    = absorb_reg;
        emit           = 1'b0;
        kind_next      = KIND_STATUS;
        value_next     = 32'd0;
        arg_out_next   = 4'(arg_reg);
        tag_write      = 1'b0;
        sel_req        = 1'b0;
        sel_first      = 1'b0;
        tag_shift      = 1'b0;
        sel_idx        = '0;
        sel_tag        = 8'd0;
        absorb_final   = 1'b0;
        done_next      = 1'b0;
        error_next     = 1'b0;
        npos           = pad_reg + 2'd1;
        aligned        = (npos == 2'd0);
        blob_dec       = blob_reg - 31'd1;

        if (!absorb_reg)
        begin
            case (phase_reg)
                PH_ADDR_FIRST:
                begin
                    if (in_byte != CHAR_SLASH)
                    begin
                        absorb_next = 1'b1;
                    end
                    else
                    begin
                        emit         = 1'b1;
                        kind_next    = KIND_ADDR_BYTE;
                        value_next   = {24'd0, in_byte};
                        arg_out_next = 4'd0;
                        phase_next   = PH_ADDR;
                    end
                end
                PH_ADDR:
                begin
                    emit         = 1'b1;
                    arg_out_next = 4'd0;
                    if (in_byte == CHAR_NUL)
                    begin
                        kind_next  = KIND_ADDR_END;
                        phase_next = aligned ? PH_TAG_FIRST : PH_ADDR_PAD;
                    end
                    else
                    begin
                        kind_next  = KIND_ADDR_BYTE;
                        value_next = {24'd0, in_byte};
                    end
                end
                PH_ADDR_PAD:
                begin
                    if (aligned)
                    begin
                        phase_next = PH_TAG_FIRST;
                    end
                end
                PH_TAG_FIRST:
                begin
                    if (in_byte != CHAR_COMMA)
                    begin
                        absorb_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_TAG;
                    end
                end
                PH_TAG:
                begin
                    if (in_byte == CHAR_NUL)
                    begin
                        if (aligned)
                        begin
                            sel_req   = 1'b1;
                            sel_first = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_TAG_PAD;
                        end
                    end
                    else if (tag_count_reg >= CNT_W'(MAX_TAGS))
                    begin
                        absorb_next = 1'b1;
                    end
                    else
                    begin
                        tag_write      = 1'b1;
                        tag_count_next = tag_count_reg + CNT_W'(1);
                    end
                end
                PH_TAG_PAD:
                begin
                    if (aligned)
                    begin
                        sel_req   = 1'b1;
                        sel_first = 1'b1;
                    end
                end
                PH_WORD:
                begin
                    acc_next  = {acc_reg[23:0], in_byte};
                    wcnt_next = wcnt_reg + 2'd1;
                    if (wcnt_reg == 2'd3)
                    begin
                        if (tag_fifo_reg[0] == CHAR_INT || tag_fifo_reg[0] == CHAR_FLOAT)
                        begin
                            emit       = 1'b1;
                            kind_next  = (tag_fifo_reg[0] == CHAR_INT) ? KIND_INT : KIND_FLOAT;
                            value_next = acc_next;
                            sel_req    = 1'b1;
                        end
                        else if (acc_next[31])
                        begin
                            absorb_next = 1'b1;
                        end
                        else
                        begin
                            emit       = 1'b1;
                            kind_next  = KIND_BLOB_LEN;
                            value_next = acc_next;
                            blob_next  = acc_next[30:0];
                            if (acc_next == 32'd0)
                            begin
                                sel_req = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_BLOB;
                            end
                        end
                    end
                end
                PH_STR:
                begin
                    emit = 1'b1;
                    if (in_byte == CHAR_NUL)
                    begin
                        kind_next = KIND_STR_END;
                        if (aligned)
                        begin
                            sel_req = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_STR_PAD;
                        end
                    end
                    else
                    begin
                        kind_next  = KIND_STR_BYTE;
                        value_next = {24'd0, in_byte};
                    end
                end
                PH_BLOB:
                begin
                    emit       = 1'b1;
                    kind_next  = KIND_BLOB_BYTE;
                    value_next = {24'd0, in_byte};
                    blob_next  = blob_dec;
                    if (blob_dec == 31'd0)
                    begin
                        if (aligned)
                        begin
                            sel_req = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_BLOB_PAD;
                        end
                    end
                end
                PH_STR_PAD, PH_BLOB_PAD:
                begin
                    if (aligned)
                    begin
                        sel_req = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            // Enter the next argument, or the trailer after the last one.
            if (sel_req)
            begin
                sel_idx   = sel_first ? '0 : arg_reg + CNT_W'(1);
                sel_tag   = sel_first ? tag_fifo_reg[0] : tag_fifo_reg[1];
                tag_shift = !sel_first;
                arg_next  = sel_idx;
                if (sel_idx >= tag_count_next)
                begin
                    phase_next = PH_TRAILER;
                end
                else if (sel_tag == CHAR_INT || sel_tag == CHAR_FLOAT
                         || sel_tag == CHAR_BLOB)
                begin
                    phase_next = PH_WORD;
                    acc_next   = 32'd0;
                    wcnt_next  = 2'd0;
                end
                else if (sel_tag == CHAR_STR)
                begin
                    phase_next = PH_STR;
                end
                else
                begin
                    absorb_next = 1'b1;
                end
            end

            pad_next = npos;
            if (absorb_next)
            begin
                emit = 1'b0;
            end
        end

        if (last_byte)
        begin
            absorb_final = absorb_next
                           || (phase_next != PH_TAG_FIRST && phase_next != PH_TRAILER);
            if (absorb_final || !emit)
            begin
                kind_next    = KIND_STATUS;
                value_next   = 32'd0;
                arg_out_next = 4'd0;
            end
            done_next      = 1'b1;
            error_next     = absorb_final;
            emit           = 1'b1;
            // Drop all per-packet state.
            phase_next     = PH_ADDR_FIRST;
            pad_next       = 2'd0;
            tag_count_next = '0;
            arg_next       = '0;
            acc_next       = 32'd0;
            wcnt_next      = 2'd0;
            blob_next      = 31'd0;
            absorb_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_ADDR_FIRST;
            pad_reg       <= 2'd0;
            tag_count_reg <= '0;
            arg_reg       <= '0;
            acc_reg       <= 32'd0;
            wcnt_reg      <= 2'd0;
            blob_reg      <= 31'd0;
            absorb_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg     <= phase_next;
                pad_reg       <= pad_next;
                tag_count_reg <= tag_count_next;
                arg_reg       <= arg_next;
                acc_reg       <= acc_next;
                wcnt_reg      <= wcnt_next;
                blob_reg      <= blob_next;
                absorb_reg    <= absorb_next;
                out_valid_reg <= emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load with each accepted byte that makes a result.
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            kind_reg    <= kind_next;
            value_reg   <= value_next;
            arg_out_reg <= arg_out_next;
            done_reg    <= done_next;
            error_reg   <= error_next;
        end
    end

    // Tag queue: write at the tail while reading tags, advance the head per argument.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < MAX_TAGS; i++)
            begin
                if (tag_write && tag_count_reg == CNT_W'(i))
                begin
                    tag_fifo_reg[i] <= in_byte;
                end
                else if (tag_shift)
                begin
                    tag_fifo_reg[i] <= tag_fifo_reg[i + 1];
                end
            end
            // Spare slot past the last tag: fill with a null as the queue advances.
            if (tag_shift)
            begin
                tag_fifo_reg[MAX_TAGS] <= CHAR_NUL;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign value     = value_reg;
    assign arg_index = arg_out_reg;
    assign done_res  = done_reg;
    assign error     = error_reg;

    a_error_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && error_reg |-> done_reg && kind_reg == KIND_STATUS)
        else $error("error flag without a status-only done result");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |=> phase_reg == PH_ADDR_FIRST && !absorb_reg
                                && tag_count_reg == '0)
        else $error("packet state not cleared after last byte");

    a_tag_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        tag_count_reg <= CNT_W'(MAX_TAGS))
        else $error("tag count beyond capacity");

    a_arg_within_tags: assert property (@(posedge clk) disable iff (!rst_n)
        arg_reg <= tag_count_reg)
        else $error("argument index beyond tag count");

    a_data_phase_has_tag: assert property (@(posedge clk) disable iff (!rst_n)
        !absorb_reg && (phase_reg == PH_WORD || phase_reg == PH_STR
                        || phase_reg == PH_BLOB) |-> arg_reg < tag_count_reg)
        else $error("argument phase with no tag left");

endmodule

`default_nettype wire
